// ----- src/pst_pkg.sv -----
// Shared types, token codes and keyword tables for the Pascal-subset tokenizer.
`default_nettype none

package pst_pkg;

    localparam int DEF_MAX_LEXEME  = 99;
    localparam int DEF_LINE_BITS   = 16;
    localparam int DEF_OFFSET_BITS = 24;

    localparam int KIND_W     = 4;
    localparam int LINE_OUT_W = 16;
    localparam int OFFS_OUT_W = 24;
    localparam int LEN_OUT_W  = 7;

    localparam int FIFO_DEPTH = 4;
    localparam int NUM_KW     = 6;
    localparam int KW_CHARS   = 8;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDENT   = 4'd0,
        KIND_NUMBER  = 4'd1,
        KIND_SEMI    = 4'd2,
        KIND_COMMA   = 4'd3,
        KIND_COLON   = 4'd4,
        KIND_ASSIGN  = 4'd5,
        KIND_EQ      = 4'd6,
        KIND_BEGIN   = 4'd7,
        KIND_END     = 4'd8,
        KIND_PROGRAM = 4'd9,
        KIND_VAR     = 4'd10,
        KIND_DOT     = 4'd11,
        KIND_INTEGER = 4'd12,
        KIND_REAL    = 4'd13,
        KIND_ERROR   = 4'd14,
        KIND_EOF     = 4'd15
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_INT   = 3'd2,
        MODE_FRAC  = 3'd3,
        MODE_COLON = 3'd4
    } t_mode;

    typedef struct packed {
        t_kind                 kind;
        logic [LINE_OUT_W-1:0] line;
        logic [OFFS_OUT_W-1:0] start;
        logic [LEN_OUT_W-1:0]  len;
        logic                  point;
        logic                  over;
        logic                  last;
    } t_token;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
        '{"p", "r", "o", "g", "r", "a", "m", 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", "e", "g", "e", "r", 8'h00},
        '{"r", "e", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd7, 4'd3, 4'd5, 4'd3, 4'd7, 4'd4};

    localparam t_kind KW_KIND [NUM_KW] = '{
        KIND_PROGRAM, KIND_VAR, KIND_BEGIN, KIND_END, KIND_INTEGER, KIND_REAL
    };

endpackage

`default_nettype wire

// ----- src/pst_scanner.sv -----
// Scanner state and the per-character token decision logic.
`default_nettype none

module pst_scanner
    import pst_pkg::*;
#(
    parameter int MAX_LEXEME  = DEF_MAX_LEXEME,
    parameter int LINE_BITS   = DEF_LINE_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    output t_push      o_push,
    output t_token     o_tok0,
    output t_token     o_tok1
);

    localparam int LEN_W = $clog2(MAX_LEXEME + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEXEME);
    localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};

    t_mode                   r_mode, n_mode;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [OFFSET_BITS-1:0]  r_start, n_start;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [NUM_KW-1:0]       r_cands, n_cands;
    logic                    r_ovf, n_ovf;

    logic is_alpha, is_digit, is_space, is_nl, is_colon;
    logic extend_ok, colon_assign, pend_valid, char_tok_valid;
    logic [NUM_KW-1:0] cont_match, begin_match;
    logic [LEN_W-1:0] ext_len;
    logic ext_ovf;
    t_kind ident_kind, char_kind;
    t_token pend_tok, char_tok, eof_tok, assign_tok;

    assign is_alpha = (i_char >= "A" && i_char <= "Z") || (i_char >= "a" && i_char <= "z");
    assign is_digit = i_char >= "0" && i_char <= "9";
    assign is_space = i_char == CH_SPACE || (i_char >= CH_TAB && i_char <= CH_CR);
    assign is_nl    = i_char == CH_NL;
    assign is_colon = i_char == CH_COLON;

    assign extend_ok = (r_mode == MODE_IDENT && (is_alpha || is_digit))
                    || (r_mode == MODE_INT && (is_digit || i_char == CH_DOT))
                    || (r_mode == MODE_FRAC && is_digit);
    assign colon_assign   = r_mode == MODE_COLON && i_char == CH_EQ;
    assign pend_valid     = r_mode != MODE_IDLE;
    assign char_tok_valid = !is_space && !is_alpha && !is_digit && !is_colon;

    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            cont_match[k] = !(r_len >= LEN_W'(KW_LEN[k]) || r_len >= LEN_W'(KW_CHARS)
                            || KW_TEXT[k][r_len[2:0]] != i_char);
            begin_match[k] = KW_TEXT[k][0] == i_char;
        end
    end

    assign ext_len = (r_len < LEN_MAX) ? r_len + LEN_W'(1) : r_len;
    assign ext_ovf = r_ovf | (r_len >= LEN_MAX);

    always_comb begin
        ident_kind = KIND_IDENT;
        if (!r_ovf) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (r_cands[k] && r_len == LEN_W'(KW_LEN[k])) begin
                    ident_kind = KW_KIND[k];
                end
            end
        end
    end

    always_comb begin
        priority if (i_char == CH_SEMI) begin
            char_kind = KIND_SEMI;
        end else if (i_char == CH_COMMA) begin
            char_kind = KIND_COMMA;
        end else if (i_char == CH_EQ) begin
            char_kind = KIND_EQ;
        end else if (i_char == CH_DOT) begin
            char_kind = KIND_DOT;
        end else begin
            char_kind = KIND_ERROR;
        end
    end

    always_comb begin
        pend_tok.line  = LINE_OUT_W'(r_line);
        pend_tok.start = OFFS_OUT_W'(r_start);
        pend_tok.last  = 1'b0;
        unique case (r_mode)
            MODE_IDENT: begin
                pend_tok.kind  = ident_kind;
                pend_tok.len   = LEN_OUT_W'(r_len);
                pend_tok.point = 1'b0;
                pend_tok.over  = r_ovf;
            end
            MODE_INT, MODE_FRAC: begin
                pend_tok.kind  = KIND_NUMBER;
                pend_tok.len   = LEN_OUT_W'(r_len);
                pend_tok.point = r_mode == MODE_FRAC;
                pend_tok.over  = r_ovf;
            end
            default: begin
                pend_tok.kind  = KIND_COLON;
                pend_tok.len   = LEN_OUT_W'(1);
                pend_tok.point = 1'b0;
                pend_tok.over  = 1'b0;
            end
        endcase

        char_tok.kind  = char_kind;
        char_tok.line  = LINE_OUT_W'(r_line);
        char_tok.start = OFFS_OUT_W'(r_offset);
        char_tok.len   = LEN_OUT_W'(1);
        char_tok.point = 1'b0;
        char_tok.over  = 1'b0;
        char_tok.last  = 1'b1;

        eof_tok       = char_tok;
        eof_tok.kind  = KIND_EOF;
        eof_tok.len   = '0;

        assign_tok       = char_tok;
        assign_tok.kind  = KIND_ASSIGN;
        assign_tok.start = OFFS_OUT_W'(r_start);
        assign_tok.len   = LEN_OUT_W'(2);
    end

    always_comb begin
        o_push = '0;
        o_tok0 = char_tok;
        o_tok1 = char_tok;
        priority if (i_eoi) begin
            o_push.first  = 1'b1;
            o_push.second = pend_valid;
            o_tok0        = pend_valid ? pend_tok : eof_tok;
            o_tok1        = eof_tok;
        end else if (extend_ok) begin
            o_push = '0;
        end else if (colon_assign) begin
            o_push.first = 1'b1;
            o_tok0       = assign_tok;
        end else begin
            o_push.first  = pend_valid || char_tok_valid;
            o_push.second = pend_valid && char_tok_valid;
            o_tok0        = pend_valid ? pend_tok : char_tok;
        end
        o_tok0.last = !o_push.second;
        o_tok1.last = 1'b1;
    end

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_offset = r_offset;
        n_start  = r_start;
        n_len    = r_len;
        n_cands  = r_cands;
        n_ovf    = r_ovf;
        if (i_valid) begin
            if (i_eoi) begin
                n_mode = MODE_IDLE;
                n_line = LINE_BITS'(1);
            end else begin
                n_offset = r_offset + OFFSET_BITS'(1);
                priority if (extend_ok) begin
                    n_len   = ext_len;
                    n_cands = r_cands & cont_match;
                    n_ovf   = ext_ovf;
                    if (r_mode == MODE_INT && i_char == CH_DOT) begin
                        n_mode = MODE_FRAC;
                    end
                end else if (colon_assign) begin
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_IDLE;
                    priority if (is_space) begin
                        if (is_nl && r_line != LINE_SAT) begin
                            n_line = r_line + LINE_BITS'(1);
                        end
                    end else if (is_alpha || is_digit) begin
                        n_start = r_offset;
                        n_len   = LEN_W'(1);
                        n_cands = begin_match;
                        n_ovf   = 1'b0;
                        n_mode  = is_alpha ? MODE_IDENT : MODE_INT;
                    end else if (is_colon) begin
                        n_start = r_offset;
                        n_len   = '0;
                        n_cands = '1;
                        n_ovf   = 1'b0;
                        n_mode  = MODE_COLON;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_line   <= LINE_BITS'(1);
            r_offset <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_cands  <= '1;
            r_ovf    <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_len    <= n_len;
            r_cands  <= n_cands;
            r_ovf    <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- src/pst_token_fifo.sv -----
// Small result queue that takes up to two tokens and gives one per cycle while the reader is ready.
`default_nettype none

module pst_token_fifo
    import pst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  t_token i_tok0,
    input  t_token i_tok1,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_tok
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_token            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              pop;
    logic [PTR_W-1:0]  wr_ptr1;

    assign o_valid = r_count != '0;
    assign o_room  = r_count <= (PTR_W + 1)'(FIFO_DEPTH - 2);
    assign o_tok   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_tok0;
        end
        if (i_push.second) begin
            r_mem[wr_ptr1] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + (PTR_W + 1)'(i_push.first)
                      + (PTR_W + 1)'(i_push.second) - (PTR_W + 1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- src/pascal_subset_tokenizer_core.sv -----
// Top level of the Pascal-subset tokenizer: input register, scanner and result queue.
`default_nettype none

// Streaming lexer for a small Pascal subset. Each input item is one source byte, or an
// end-of-input mark in tuser. Tokens leave one per cycle on the master side while tready
// is high, with their kind, line, start offset and length; tlast marks the final token
// caused by one input item. Input is taken at one byte per cycle while the queue has
// room: the item is held in an input register and is then scanned into a four-entry
// result queue. An item that closes a pending token and is a token itself gives two
// results; the input register waits while the queue has fewer than two free entries.
// An item passes the input register and the result queue before its first result leaves.
// End of input flushes the pending token, adds an eof token and sets the line back to one.
module pascal_subset_tokenizer_core
    import pst_pkg::*;
#(
    parameter int MAX_LEXEME  = DEF_MAX_LEXEME,
    parameter int LINE_BITS   = DEF_LINE_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // character
    input  logic [0:0]  s_axis_tuser,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // line_number, start_offset, lexeme_length,
                                        // has_point, too_long, zero fill
    output logic [3:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;
    logic       room, advance, accept;
    t_push      push;
    t_token     tok0, tok1, out_tok;

    assign advance       = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= s_axis_tdata;
            r_in_eoi  <= s_axis_tuser[0];
        end
    end

    pst_scanner #(
        .MAX_LEXEME  (MAX_LEXEME),
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_char  (r_in_char),
        .i_eoi   (r_in_eoi),
        .o_push  (push),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    t_push push_gated;
    assign push_gated.first  = push.first && advance;
    assign push_gated.second = push.second && advance;

    pst_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_gated),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (out_tok)
    );

    assign m_axis_tdata = {7'b0, out_tok.over, out_tok.point, out_tok.len,
                           out_tok.start, out_tok.line};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.last;

endmodule

`default_nettype wire

// ----- bench/tb_pascal_subset_tokenizer_core.sv -----
// Self-checking testbench for the Pascal-subset tokenizer: directed script, random source text.
`timescale 1ns / 1ps

module tb_pascal_subset_tokenizer_core;
    import pst_pkg::*;

    localparam int MAX_LEX = DEF_MAX_LEXEME;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        logic        typed;
        t_kind       kind;
        logic [15:0] line;
        logic [23:0] start;
        logic [6:0]  len;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_data = 8'h00;
    logic [0:0]  s_user = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;   // line_number, start_offset, lexeme_length,
                                 // has_point, too_long, zero fill
    logic [3:0]  m_axis_tuser;   // token_kind
    logic        m_axis_tlast;

    int idle_pct = 11;
    int hold_req = 0;
    int fails = 0;
    int sent_items = 0;
    int step_tokens = 0;

    t_token expected_tokens [$];

    t_mode       lex_mode = MODE_IDLE;
    logic [15:0] lex_line = 16'd1;
    logic [23:0] lex_offset = '0;
    logic [23:0] lex_start = '0;
    int          lex_len = 0;
    bit          lex_over = 1'b0;
    logic [7:0]  lex_text [8];

    string kw_word [6] = '{"program", "var", "begin", "end", "integer", "real"};
    t_kind kw_kind [6] = '{KIND_PROGRAM, KIND_VAR, KIND_BEGIN, KIND_END,
                           KIND_INTEGER, KIND_REAL};
    logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    t_row script [24] = '{
        '{8'h3B, 1'b0, 1'b1, KIND_SEMI,  16'd1, 24'd0,  7'd1},
        '{8'h00, 1'b0, 1'b1, KIND_ERROR, 16'd1, 24'd1,  7'd1},
        '{8'hFF, 1'b0, 1'b1, KIND_ERROR, 16'd1, 24'd2,  7'd1},
        '{8'h80, 1'b0, 1'b1, KIND_ERROR, 16'd1, 24'd3,  7'd1},
        '{8'h0A, 1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"e",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"n",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"d",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{":",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"=",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"1",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{".",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{".",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"2",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"a",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{",",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{":",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{8'h0D, 1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"=",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{8'h00, 1'b1, 1'b1, KIND_EOF,   16'd2, 24'd19, 7'd0},
        '{8'h09, 1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{"v",   1'b0, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{8'hFF, 1'b1, 1'b0, KIND_IDENT, 16'd0, 24'd0,  7'd0},
        '{8'h7F, 1'b0, 1'b1, KIND_ERROR, 16'd1, 24'd21, 7'd1}
    };

    pascal_subset_tokenizer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("** pascal_subset_tokenizer_core: FAILED **");
        $finish;
    end

    function void push_token(t_kind kind, logic [23:0] start, int len, bit point, bit over);
        t_token t;
        t.kind  = kind;
        t.line  = lex_line;
        t.start = start;
        t.len   = len[6:0];
        t.point = point;
        t.over  = over;
        t.last  = 1'b0;
        expected_tokens.push_back(t);
        step_tokens++;
    endfunction

    function void open_lexeme(t_mode mode);
        lex_mode  = mode;
        lex_start = lex_offset;
        lex_len   = 0;
        lex_over  = 1'b0;
    endfunction

    function void grow_lexeme(logic [7:0] c);
        if (lex_len < MAX_LEX) begin
            if (lex_len < 8) lex_text[lex_len] = c;
            lex_len++;
        end else begin
            lex_over = 1'b1;
        end
    endfunction

    function t_kind ident_kind();
        t_kind kind;
        bit    hit;
        kind = KIND_IDENT;
        if (!lex_over) begin
            for (int k = 0; k < 6; k++) begin
                if (kw_word[k].len() == lex_len) begin
                    hit = 1'b1;
                    for (int i = 0; i < lex_len; i++)
                        if (lex_text[i] != kw_word[k][i]) hit = 1'b0;
                    if (hit) kind = kw_kind[k];
                end
            end
        end
        return kind;
    endfunction

    function void flush_pending();
        case (lex_mode)
            MODE_IDENT: push_token(ident_kind(), lex_start, lex_len, 1'b0, lex_over);
            MODE_INT, MODE_FRAC: begin
                push_token(KIND_NUMBER, lex_start, lex_len, lex_mode == MODE_FRAC, lex_over);
            end
            MODE_COLON: push_token(KIND_COLON, lex_start, 1, 1'b0, 1'b0);
            default: ;
        endcase
        lex_mode = MODE_IDLE;
    endfunction

    function void scan_byte(logic [7:0] c);
        bit alpha;
        bit digit;
        bit blank;
        alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        digit = c >= "0" && c <= "9";
        blank = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        case (lex_mode)
            MODE_IDENT: if (alpha || digit) begin
                grow_lexeme(c);
                return;
            end
            MODE_INT: if (digit) begin
                grow_lexeme(c);
                return;
            end else if (c == CH_DOT) begin
                grow_lexeme(c);
                lex_mode = MODE_FRAC;
                return;
            end
            MODE_FRAC: if (digit) begin
                grow_lexeme(c);
                return;
            end
            MODE_COLON: if (c == CH_EQ) begin
                lex_mode = MODE_IDLE;
                push_token(KIND_ASSIGN, lex_start, 2, 1'b0, 1'b0);
                return;
            end
            default: ;
        endcase
        flush_pending();
        if (blank) begin
            if (c == CH_NL && lex_line != 16'hFFFF) lex_line++;
        end else if (alpha) begin
            open_lexeme(MODE_IDENT);
            grow_lexeme(c);
        end else if (digit) begin
            open_lexeme(MODE_INT);
            grow_lexeme(c);
        end else if (c == CH_COLON) begin
            open_lexeme(MODE_COLON);
        end else if (c == CH_SEMI) begin
            push_token(KIND_SEMI, lex_offset, 1, 1'b0, 1'b0);
        end else if (c == CH_COMMA) begin
            push_token(KIND_COMMA, lex_offset, 1, 1'b0, 1'b0);
        end else if (c == CH_EQ) begin
            push_token(KIND_EQ, lex_offset, 1, 1'b0, 1'b0);
        end else if (c == CH_DOT) begin
            push_token(KIND_DOT, lex_offset, 1, 1'b0, 1'b0);
        end else begin
            push_token(KIND_ERROR, lex_offset, 1, 1'b0, 1'b0);
        end
    endfunction

    function void tokenize_item(logic [7:0] c, bit eoi);
        step_tokens = 0;
        if (eoi) begin
            flush_pending();
            push_token(KIND_EOF, lex_offset, 0, 1'b0, 1'b0);
            lex_line = 16'd1;
            lex_mode = MODE_IDLE;
        end else begin
            scan_byte(c);
            lex_offset++;
        end
        if (step_tokens > 0) expected_tokens[$].last = 1'b1;
    endfunction

    function string token_str(t_token t);
        return $sformatf("kind=%0d line=%0d start=%0d len=%0d point=%0b over=%0b last=%0b",
                         t.kind, t.line, t.start, t.len, t.point, t.over, t.last);
    endfunction

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = t_kind'(m_axis_tuser);
            got.line  = m_axis_tdata[15:0];
            got.start = m_axis_tdata[39:16];
            got.len   = m_axis_tdata[46:40];
            got.point = m_axis_tdata[47];
            got.over  = m_axis_tdata[48];
            got.last  = m_axis_tlast;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token: expected none, got %s", $time, token_str(got));
                fails++;
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want || m_axis_tdata[55:49] !== '0) begin
                    $display("%0t: token mismatch: expected %s, got %s fill=%0h", $time,
                             token_str(want), token_str(got), m_axis_tdata[55:49]);
                    fails++;
                end
            end
        end
    end

    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= $urandom_range(0, 99) >= idle_pct;
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input bit eoi);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_user  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        tokenize_item(c, eoi);
    endtask

    task automatic send_run(input logic [7:0] c, input int count);
        repeat (count) send_item(c, 1'b0);
    endtask

    task automatic drain_tokens();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    function logic [7:0] any_letter();
        return $urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 25))
                                    : 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function logic [7:0] any_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_random_lexeme();
        logic [7:0] text [$];
        int pick;
        int k;
        string word;
        pick = $urandom_range(0, 99);
        if (pick < 16) begin
            k = $urandom_range(0, 5);
            word = kw_word[k];
            for (int i = 0; i < word.len(); i++) text.push_back(word[i]);
            case ($urandom_range(0, 5))
                0: text[0] = text[0] - 8'h20;
                1: void'(text.pop_back());
                2: text.push_back($urandom_range(0, 1) ? any_letter() : any_digit());
                default: ;
            endcase
        end else if (pick < 36) begin
            text.push_back(any_letter());
            repeat ($urandom_range(0, 9))
                text.push_back($urandom_range(0, 2) ? any_letter() : any_digit());
        end else if (pick < 54) begin
            repeat ($urandom_range(1, 5)) text.push_back(any_digit());
            if ($urandom_range(0, 9) < 4) begin
                text.push_back(CH_DOT);
                repeat ($urandom_range(0, 3)) text.push_back(any_digit());
                if ($urandom_range(0, 9) == 0) begin
                    text.push_back(CH_DOT);
                    text.push_back(any_digit());
                end
            end
        end else if (pick < 70) begin
            case ($urandom_range(0, 5))
                0: text.push_back(CH_SEMI);
                1: text.push_back(CH_COMMA);
                2: text.push_back(CH_EQ);
                3: text.push_back(CH_DOT);
                4: text.push_back(CH_COLON);
                default: begin
                    text.push_back(CH_COLON);
                    text.push_back(CH_EQ);
                end
            endcase
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 3)) text.push_back(blanks[$urandom_range(0, 5)]);
        end else if (pick < 88) begin
            text.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 91) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            repeat ($urandom_range(1, 3)) text.push_back(any_digit());
            repeat ($urandom_range(1, 3)) text.push_back(any_letter());
        end
        if ($urandom_range(0, 1)) begin
            text.push_back($urandom_range(0, 2) ? blanks[$urandom_range(0, 5)] : CH_NL);
        end
        foreach (text[i]) send_item(text[i], 1'b0);
    endtask

    initial begin
        t_token typed_token;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            send_item(script[r].ch, script[r].eoi);
            if (script[r].typed) begin
                repeat (step_tokens) void'(expected_tokens.pop_back());
                typed_token.kind  = script[r].kind;
                typed_token.line  = script[r].line;
                typed_token.start = script[r].start;
                typed_token.len   = script[r].len;
                typed_token.point = 1'b0;
                typed_token.over  = 1'b0;
                typed_token.last  = 1'b1;
                expected_tokens.push_back(typed_token);
            end
        end

        hold_req <= hold_req + 1;
        while (sent_items < 110) send_random_lexeme();
        drain_tokens();

        idle_pct <= 0;
        @(posedge i_clk);
        while (sent_items < 190) send_random_lexeme();
        idle_pct <= 11;
        hold_req <= hold_req + 1;
        while (sent_items < 260) send_random_lexeme();

        send_run("a", MAX_LEX);
        send_item(CH_SPACE, 1'b0);
        for (int i = 0; i < kw_word[2].len(); i++) send_item(kw_word[2][i], 1'b0);
        send_run("x", MAX_LEX - 4);
        send_item(CH_SEMI, 1'b0);
        send_item("1", 1'b0);
        send_item(CH_DOT, 1'b0);
        send_run("7", MAX_LEX);
        send_item(CH_COMMA, 1'b0);
        send_item(8'h00, 1'b1);

        send_run(CH_NL, 40);
        send_item("x", 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(8'hFF, 1'b1);

        drain_tokens();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("** pascal_subset_tokenizer_core: PASSED **");
        end else begin
            $display("** pascal_subset_tokenizer_core: FAILED **");
        end
        $finish;
    end

endmodule
